### rtl/msp_enc_pkg.sv
// Package for the MSP frame encoder: word and job types, framing constants,
// and the CRC-8 DVB-S2 byte update. No dependencies.
package msp_enc_pkg;

    // command codes of an input word
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // framing characters
    localparam logic [7:0] START_CHAR = 8'h24;  // '$'
    localparam logic [7:0] DIR_CHAR   = 8'h3E;  // '>'
    localparam logic [7:0] V1_MAGIC   = 8'h4D;  // 'M'
    localparam logic [7:0] V2_MAGIC   = 8'h58;  // 'X'
    localparam logic [7:0] V2_FLAG    = 8'h00;
    localparam logic [7:0] CRC8_POLY  = 8'hD5;

    // header byte steps: '$' magic '>' then the fields
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_FIRST   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FIELDS  = 3'd3;  // first byte folded into check
    localparam logic [STEP_W-1:0] V1_HDR_LAST  = 3'd4;
    localparam logic [STEP_W-1:0] V2_HDR_LAST  = 3'd7;

    // job queue between front and back (power of two)
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        command;
        logic        use_v2;
        logic [15:0] msg_id;
        logic [15:0] payload_len;
        logic [7:0]  data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_word_t;

    // one classified item: a frame start or a payload byte, and whether
    // the check byte follows it
    typedef struct packed {
        logic        command;
        logic        use_v2;
        logic [15:0] msg_id;
        logic [15:0] payload_len;
        logic [7:0]  data_byte;
        logic        close;
    } job_t;

    typedef enum logic {
        BK_RUN,
        BK_CHECK
    } back_state_t;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC8_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/msp_enc_front.sv
// Front end of the MSP frame encoder: accepts input words, tracks the open
// frame and pushes classified jobs. Depends on msp_enc_pkg.
module msp_enc_front
    import msp_enc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  in_word_t cmd_word,
    input  logic     q_full,
    output logic     push,
    output job_t     job
);

    logic        open_reg, open_next;
    logic [15:0] left_reg, left_next;
    logic        accept;
    logic [15:0] frame_len;

    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !q_full;

    // v1 keeps the low byte of the length only
    assign frame_len = cmd_word.use_v2 ? cmd_word.payload_len
                                       : {8'h00, cmd_word.payload_len[7:0]};

    always_comb
    begin
        open_next        = open_reg;
        left_next        = left_reg;
        push             = 1'b0;
        job.command      = cmd_word.command;
        job.use_v2       = cmd_word.use_v2;
        job.msg_id       = cmd_word.msg_id;
        job.payload_len  = cmd_word.payload_len;
        job.data_byte    = cmd_word.data_byte;
        job.close        = 1'b0;
        priority if (accept && cmd_word.command == CMD_START)
        begin
            // a start abandons any open frame
            push      = 1'b1;
            left_next = frame_len;
            open_next = (frame_len != 16'd0);
            job.close = (frame_len == 16'd0);
        end
        else if (accept && open_reg)
        begin
            push      = 1'b1;
            left_next = left_reg - 16'd1;
            open_next = (left_reg != 16'd1);
            job.close = (left_reg == 16'd1);
        end
        else
        begin
            // drop payload with no frame open
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            left_reg <= 16'd0;
        end
        else
        begin
            open_reg <= open_next;
            left_reg <= left_next;
        end
    end

endmodule

### rtl/msp_enc_queue.sv
// Short job queue between the front and back of the MSP frame encoder.
// Depends on msp_enc_pkg.
module msp_enc_queue
    import msp_enc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t job_in,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/msp_enc_back.sv
// Back end of the MSP frame encoder: sequences header, payload and check
// bytes from queued jobs into the output register. Depends on msp_enc_pkg.
module msp_enc_back
    import msp_enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head,
    output logic      pop,
    output logic      tx_valid,
    input  logic      tx_stall,
    output out_word_t tx_word
);

    back_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [7:0]        acc_reg, acc_next;
    logic              v2_reg, v2_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_reg, out_next;

    logic              adv;
    logic              job_done;
    logic [STEP_W-1:0] hdr_last;
    logic              emit;
    logic [7:0]        emit_byte;
    logic              emit_end;
    logic [7:0]        hdr_byte;

    // the output register takes a new word when empty or being taken
    assign adv      = !out_valid_reg || !tx_stall;
    assign hdr_last = head.use_v2 ? V2_HDR_LAST : V1_HDR_LAST;
    assign job_done = (head.command == CMD_DATA) || (step_reg == hdr_last);

    always_comb
    begin
        unique case (step_reg)
            3'd0:    hdr_byte = START_CHAR;
            3'd1:    hdr_byte = head.use_v2 ? V2_MAGIC : V1_MAGIC;
            3'd2:    hdr_byte = DIR_CHAR;
            3'd3:    hdr_byte = head.use_v2 ? V2_FLAG : head.payload_len[7:0];
            3'd4:    hdr_byte = head.msg_id[7:0];
            3'd5:    hdr_byte = head.msg_id[15:8];
            3'd6:    hdr_byte = head.payload_len[7:0];
            default: hdr_byte = head.payload_len[15:8];
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (head_valid && adv && job_done && head.close)
                begin
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                if (adv)
                begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        emit      = 1'b0;
        emit_byte = acc_reg;
        emit_end  = 1'b0;
        pop       = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        v2_next   = v2_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (head_valid && adv)
                begin
                    emit = 1'b1;
                    pop  = job_done;
                    if (head.command == CMD_START)
                    begin
                        emit_byte = hdr_byte;
                        step_next = job_done ? STEP_FIRST : step_reg + 1'b1;
                        if (step_reg == STEP_FIRST)
                        begin
                            acc_next = 8'h00;
                            v2_next  = head.use_v2;
                        end
                        else if (step_reg >= STEP_FIELDS)
                        begin
                            acc_next = v2_reg ? crc8_feed(acc_reg, hdr_byte)
                                              : acc_reg ^ hdr_byte;
                        end
                    end
                    else
                    begin
                        emit_byte = head.data_byte;
                        acc_next  = v2_reg ? crc8_feed(acc_reg, head.data_byte)
                                           : acc_reg ^ head.data_byte;
                    end
                end
            end
            BK_CHECK:
            begin
                emit      = adv;
                emit_byte = acc_reg;
                emit_end  = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        out_valid_next = adv ? emit : out_valid_reg;
        out_next       = out_reg;
        if (adv)
        begin
            out_next.out_byte  = emit_byte;
            out_next.frame_end = emit_end;
        end
    end

    assign tx_valid = out_valid_reg;
    assign tx_word  = out_reg;

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            step_reg      <= STEP_FIRST;
            acc_reg       <= 8'h00;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/msp_frame_encoder_top.sv
// MSP frame encoder top level: front end, job queue and byte sequencer.
// Depends on msp_enc_pkg, msp_enc_front, msp_enc_queue, msp_enc_back.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_word) takes one word per item:
//   command = start opens a frame (version, message id, payload length),
//   command = data delivers one payload byte. A data word with no frame open
//   is taken and dropped. A start while a frame is open abandons that frame.
//   tx channel (tx_valid / tx_stall / tx_word) gives the framed bytes one
//   word at a time; frame_end marks the check byte (XOR for v1, CRC-8
//   DVB-S2 for v2) that closes each frame.
// Path: a taken item is written into the job queue, and its first byte then
//   passes through the output register before it shows on tx.
// Throughput: one output byte per cycle unless tx_stall holds, set by the
//   byte sequencer in the back end. A payload word gives one byte, two
//   with the check byte; a start word gives 5 (v1) or 8 (v2) header bytes,
//   one more for a zero length. The front accepts while the two-entry
//   queue has room, so items arrive back to back while earlier bytes drain.
// Reset: rst_n clears the open-frame state, the queue and the output
//   valid flag; no frame is open after reset.
// Stall: while tx_stall holds, the output word holds, the sequencer stops,
//   the queue fills and then cmd_stall rises.
module msp_frame_encoder_top
    import msp_enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  in_word_t  cmd_word,
    output logic      tx_valid,
    input  logic      tx_stall,
    output out_word_t tx_word
);

    logic push;
    job_t job;
    logic q_full;
    logic pop;
    logic head_valid;
    job_t head;

    // classify words and track the open frame
    msp_enc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_full    (q_full),
        .push      (push),
        .job       (job)
    );

    // decouple acceptance from byte emission
    msp_enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .job_in     (job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // emit header, payload and check bytes
    msp_enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .tx_valid   (tx_valid),
        .tx_stall   (tx_stall),
        .tx_word    (tx_word)
    );

endmodule

### verif/msp_frame_encoder_top_tb.sv
// Self-checking testbench for msp_frame_encoder_top: MSP v1/v2 frame bytes
// are predicted per command word and checked against the tx channel.
// Depends on msp_enc_pkg and the msp_frame_encoder_top RTL.
`timescale 1ns / 1ps

module msp_frame_encoder_top_tb;
    import msp_enc_pkg::*;

    localparam int unsigned RANDOM_WORDS = 420;   // useful random words to plan
    localparam int unsigned HOLD_CYCLES  = 150;   // long receiver hold-off
    localparam int unsigned MAX_REPORTS  = 30;    // cap printed mismatch lines

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    in_word_t  cmd_word = '0;
    logic      tx_valid;
    logic      tx_stall = 1'b0;
    out_word_t tx_word;

    msp_frame_encoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_word   (tx_word)
    );

    // Command words waiting to be offered, and wire bytes the encoder still owes.
    in_word_t  pending_words[$];
    out_word_t wire_bytes_due[$];

    // Encoder state as the predictor sees it.
    logic        enc_open  = 1'b0;
    logic        enc_v2    = 1'b0;
    logic [15:0] enc_left  = '0;
    logic [7:0]  enc_check = '0;

    int unsigned words_planned = 0;
    int unsigned words_taken   = 0;
    int unsigned mismatches    = 0;
    int unsigned bytes_checked = 0;
    int unsigned frames_begun  = 0;
    int unsigned frames_closed = 0;
    int unsigned words_dropped = 0;

    logic cmd_taken = 1'b0;   // last offered word went in at the previous rising edge
    logic hold_rx   = 1'b0;   // receiver holds off on purpose while this is high

    // Free-running clock, 2 ns period.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // CRC-8 DVB-S2 (poly from the package, MSB first), one byte at a time.
    function automatic logic [7:0] crc8_dvb_s2_step(input logic [7:0] crc,
                                                    input logic [7:0] data);
        logic [7:0] acc;
        logic       msb;
        acc = crc ^ data;
        for (int bit_idx = 0; bit_idx < 8; bit_idx++)
        begin
            msb = acc[7];
            acc = acc << 1;
            if (msb)
            begin
                acc = acc ^ CRC8_POLY;
            end
        end
        return acc;
    endfunction

    // Queue one byte the encoder must put on the wire.
    function automatic void due_byte(input logic [7:0] value, input logic last);
        out_word_t w;
        w.out_byte  = value;
        w.frame_end = last;
        wire_bytes_due.push_back(w);
    endfunction

    // Emit the check byte and close the open frame.
    function automatic void close_frame();
        due_byte(enc_check, 1'b1);
        enc_open = 1'b0;
        frames_closed++;
    endfunction

    // Work out the wire bytes that one accepted command word produces.
    function automatic void encode_word(input in_word_t w);
        logic [7:0] hdr [0:4];
        if (w.command == CMD_START)
        begin
            // A start abandons any open frame without its check byte.
            enc_v2    = w.use_v2;
            enc_check = 8'h00;
            frames_begun++;
            due_byte(START_CHAR, 1'b0);
            if (enc_v2)
            begin
                due_byte(V2_MAGIC, 1'b0);
                due_byte(DIR_CHAR, 1'b0);
                hdr = '{V2_FLAG, w.msg_id[7:0], w.msg_id[15:8],
                        w.payload_len[7:0], w.payload_len[15:8]};
                foreach (hdr[i])
                begin
                    due_byte(hdr[i], 1'b0);
                    enc_check = crc8_dvb_s2_step(enc_check, hdr[i]);
                end
                enc_left = w.payload_len;
            end
            else
            begin
                // v1 keeps only the low bytes of length and id.
                due_byte(V1_MAGIC, 1'b0);
                due_byte(DIR_CHAR, 1'b0);
                due_byte(w.payload_len[7:0], 1'b0);
                due_byte(w.msg_id[7:0], 1'b0);
                enc_check = w.payload_len[7:0] ^ w.msg_id[7:0];
                enc_left  = {8'h00, w.payload_len[7:0]};
            end
            enc_open = 1'b1;
            if (enc_left == 16'd0)
            begin
                close_frame();
            end
        end
        else if (!enc_open)
        begin
            // Stray payload byte: the encoder drops it.
            words_dropped++;
        end
        else
        begin
            due_byte(w.data_byte, 1'b0);
            enc_check = enc_v2 ? crc8_dvb_s2_step(enc_check, w.data_byte)
                               : enc_check ^ w.data_byte;
            enc_left = enc_left - 16'd1;
            if (enc_left == 16'd0)
            begin
                close_frame();
            end
        end
    endfunction

    // Print one mismatch line (up to a cap) and count it.
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (mismatches < MAX_REPORTS)
        begin
            $display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, want, got);
        end
        mismatches++;
    endtask

    // Idle odds in percent: sender light and receiver heavy first,
    // then the other way round, then no idling at all.
    function automatic int unsigned idle_percent(input logic for_sender);
        if (words_taken < words_planned / 3)
        begin
            return for_sender ? 19 : 62;
        end
        else if (words_taken < (2 * words_planned) / 3)
        begin
            return for_sender ? 62 : 19;
        end
        return 0;
    endfunction

    // Stimulus builders. Fields a word does not use get random values so that
    // every input bit toggles.
    task automatic add_start(input logic v2, input logic [15:0] id,
                             input logic [15:0] len);
        in_word_t w;
        w.command     = CMD_START;
        w.use_v2      = v2;
        w.msg_id      = id;
        w.payload_len = len;
        w.data_byte   = 8'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic add_data(input logic [7:0] value);
        in_word_t w;
        w.command     = CMD_DATA;
        w.use_v2      = 1'($urandom);
        w.msg_id      = 16'($urandom);
        w.payload_len = 16'($urandom);
        w.data_byte   = value;
        pending_words.push_back(w);
    endtask

    // Start a frame and send the first count payload bytes with random content.
    task automatic add_frame(input logic v2, input logic [15:0] len,
                             input int unsigned count);
        add_start(v2, 16'($urandom), len);
        repeat (count) add_data(8'($urandom));
    endtask

    // Driver: offer the next word at the falling edge; hold the current one
    // until it has been taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || cmd_taken)
        begin
            if (pending_words.size() != 0 &&
                (hold_rx || $urandom_range(0, 99) >= idle_percent(1'b1)))
            begin
                cmd_word  <= pending_words.pop_front();
                cmd_valid <= 1'b1;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, or solidly during the hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            tx_stall <= 1'b0;
        end
        else
        begin
            tx_stall <= hold_rx || ($urandom_range(0, 99) < idle_percent(1'b0));
        end
    end

    // Monitor: at each rising edge predict from a taken command word, then
    // check a taken tx word against the oldest byte still due.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_taken <= cmd_valid && !cmd_stall;
            if (cmd_valid && !cmd_stall)
            begin
                encode_word(cmd_word);
                words_taken <= words_taken + 1;
            end
            if (tx_valid && !tx_stall)
            begin
                if (wire_bytes_due.size() == 0)
                begin
                    report_mismatch("tx word with nothing due, byte", 0, tx_word.out_byte);
                end
                else
                begin
                    if (tx_word.out_byte != wire_bytes_due[0].out_byte)
                    begin
                        report_mismatch("out_byte", wire_bytes_due[0].out_byte,
                                        tx_word.out_byte);
                    end
                    if (tx_word.frame_end != wire_bytes_due[0].frame_end)
                    begin
                        report_mismatch("frame_end", wire_bytes_due[0].frame_end,
                                        tx_word.frame_end);
                    end
                    void'(wire_bytes_due.pop_front());
                    bytes_checked++;
                end
            end
        end
    end

    // Long receiver hold-off once the run is under way: the sender keeps
    // offering, so the job queue fills and cmd_stall must rise.
    initial
    begin
        while (words_taken < 40)
        begin
            @(posedge clk);
        end
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    // Hard limit on the run; far above the slowest legal run.
    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    // Main sequence: build stimulus, release reset, wait for the drain, report.
    initial
    begin
        int unsigned useful;
        int unsigned pick;
        int unsigned len;
        int unsigned sent;
        logic        v2;
        logic        left_open;

        // Directed words first.
        add_data(8'h5A);                    // stray byte before any frame: drop
        add_start(1'b0, 16'h0000, 16'h0000); // v1, empty payload
        add_start(1'b1, 16'hFFFF, 16'h0000); // v2, empty payload, all-ones id
        add_start(1'b0, 16'hFF00, 16'hFF00); // v1 drops high bytes: empty again
        add_start(1'b0, 16'h00AB, 16'h0003);
        add_data(8'h00);
        add_data(8'hFF);
        add_data(8'hA5);
        add_start(1'b1, 16'h1234, 16'h0002);
        add_data(8'hFF);
        add_data(8'h00);
        add_data(8'h33);                    // stray byte after a closed frame
        add_start(1'b1, 16'h8001, 16'hFFFF); // huge v2 length, abandoned below
        add_data(8'h80);
        add_start(1'b0, 16'h007F, 16'h8001); // start while open: abandon, v1 len 1
        add_data(8'h01);
        add_start(1'b1, 16'h0000, 16'h0001);
        add_data(8'hFF);

        // Random part: mostly complete frames, some stray bytes and some
        // frames cut short by the next start.
        useful    = 0;
        left_open = 1'b0;
        while (useful < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            v2   = 1'($urandom);
            if (pick < 8)
            begin
                if (!left_open)
                begin
                    repeat ($urandom_range(1, 3)) add_data(8'($urandom));
                end
            end
            else if (pick < 18)
            begin
                // Broken frame: start, a few bytes, never closed.
                len  = v2 ? $urandom_range(1, 65535) : $urandom_range(1, 255);
                sent = $urandom_range(0, (len < 6) ? len - 1 : 5);
                add_frame(v2, v2 ? 16'(len) : {8'($urandom), 8'(len)}, sent);
                useful    += 1 + sent;
                left_open  = 1'b1;
            end
            else
            begin
                // Complete frame, now and then a long one.
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 100)
                                                   : $urandom_range(0, 8);
                add_frame(v2, v2 ? 16'(len) : {8'($urandom), 8'(len)}, len);
                useful    += 1 + len;
                left_open  = 1'b0;
            end
        end
        words_planned = pending_words.size();

        // Hold reset, then release it at a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every word to go in and every due byte to come out.
        while (words_taken < words_planned)
        begin
            @(posedge clk);
        end
        while (wire_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        // Keep running after the drain to catch any stray output.
        repeat (12) @(posedge clk);

        $display("Run covered %0d command words: %0d frames started, %0d closed, %0d dropped",
                 words_planned, frames_begun, frames_closed, words_dropped);
        $display("Checked %0d wire bytes under sender gaps, receiver stalls and a hold-off",
                 bytes_checked);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### sim.f
rtl/msp_enc_pkg.sv
rtl/msp_enc_front.sv
rtl/msp_enc_queue.sv
rtl/msp_enc_back.sv
rtl/msp_frame_encoder_top.sv
verif/msp_frame_encoder_top_tb.sv
